@@ sv/tbc_pkg.sv @@
// tea block cipher package: constants, config register codes and round helpers
// no dependencies; used by the interfaces and by tea_block_cipher
`default_nettype none

package tbc_pkg;

  localparam logic [31:0] DELTA = 32'h9e37_79b9;
  localparam int unsigned ROUNDS_DEFAULT = 32;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_WORD0 = 3'd0,
    REG_KEY_WORD1 = 3'd1,
    REG_KEY_WORD2 = 3'd2,
    REG_KEY_WORD3 = 3'd3,
    REG_DIRECTION = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_t;

  // delta times n, modulo 2^32
  function automatic word_t round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(n) * 64'(DELTA);
    return prod[WORD_W-1:0];
  endfunction

  function automatic word_t mix(input word_t v, input word_t sum,
                                input word_t ka, input word_t kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

@@ sv/tbc_if.sv @@
// valid/ready channel interfaces for the tea block cipher
// depends on tbc_pkg for word and register index widths
`default_nettype none

interface tbc_block_if;
  logic             valid;
  logic             ready;
  tbc_pkg::word_t   block_high;
  tbc_pkg::word_t   block_low;
  modport source (output valid, output block_high, output block_low, input ready);
  modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

interface tbc_result_if;
  logic             valid;
  logic             ready;
  tbc_pkg::word_t   result_high;
  tbc_pkg::word_t   result_low;
  modport source (output valid, output result_high, output result_low, input ready);
  modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

interface tbc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [tbc_pkg::CFG_INDEX_W-1:0]       index;
  tbc_pkg::word_t                        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/tea_block_cipher.sv @@
// tea block cipher top level: config registers and an unrolled half-round pipeline
// depends on tbc_pkg and the channel interfaces in tbc_if.sv
//
//   channel   dir   payload                     accepted when
//   cfg       in    index[2:0], data[31:0]      valid & ready (ready always high)
//   blocks    in    block_high, block_low       valid & ready
//   results   out   result_high, result_low     valid & ready
//
// one half-round per stage, 2*ROUNDS stages: one item per cycle sustained while results
// are ready; each stage holds one key-mix add chain (shift/add, xor, add/sub)
// rst clears the key words, direction and all stage valid bits
// a stage loads when it is empty or its successor loads, so bubbles close up under
// a stall on results and nothing is dropped or repeated
`default_nettype none

module tea_block_cipher #(
  parameter int unsigned ROUNDS = tbc_pkg::ROUNDS_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  tbc_cfg_if.sink    cfg,
  tbc_block_if.sink  blocks,
  tbc_result_if.source results
);
  import tbc_pkg::*;

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  word_t key [4];
  dir_t  direction;

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] load;
  word_t a [NSTAGE];
  word_t b [NSTAGE];

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]    <= '0;
      key[1]    <= '0;
      key[2]    <= '0;
      key[3]    <= '0;
      direction <= DIR_ENCRYPT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_WORD0: key[0] <= cfg.data;
        REG_KEY_WORD1: key[1] <= cfg.data;
        REG_KEY_WORD2: key[2] <= cfg.data;
        REG_KEY_WORD3: key[3] <= cfg.data;
        REG_DIRECTION: direction <= dir_t'(cfg.data[0]);
        default: ;
      endcase
    end
  end

  assign blocks.ready        = load[0];
  assign results.valid       = v[NSTAGE-1];
  assign results.result_high = a[NSTAGE-1];
  assign results.result_low  = b[NSTAGE-1];

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    localparam int unsigned RND = s / 2;
    localparam bit ODD = (s % 2) == 1;
    localparam word_t SUM_ENC = round_sum(RND + 1);
    localparam word_t SUM_DEC = round_sum(ROUNDS - RND);

    logic  v_in;
    word_t a_in;
    word_t b_in;
    logic  upd_left;
    logic  dec;
    word_t src;
    word_t dst;
    word_t ka;
    word_t kb;
    word_t sum;
    word_t m;
    word_t res;

    if (s == 0) begin : g_first
      assign v_in = blocks.valid;
      assign a_in = blocks.block_high;
      assign b_in = blocks.block_low;
    end else begin : g_mid
      assign v_in = v[s-1];
      assign a_in = a[s-1];
      assign b_in = b[s-1];
    end

    if (s == NSTAGE - 1) begin : g_last_ld
      assign load[s] = !v[s] || results.ready;
    end else begin : g_mid_ld
      assign load[s] = !v[s] || load[s+1];
    end

    // encrypt: even stage updates the left half; decrypt runs the halves in reverse
    always_comb begin
      dec      = (direction == DIR_DECRYPT);
      upd_left = dec ? ODD : !ODD;
      src      = upd_left ? b_in : a_in;
      dst      = upd_left ? a_in : b_in;
      ka       = upd_left ? key[0] : key[2];
      kb       = upd_left ? key[1] : key[3];
      sum      = dec ? SUM_DEC : SUM_ENC;
      m        = mix(src, sum, ka, kb);
      res      = dec ? (dst - m) : (dst + m);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (load[s]) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (load[s]) begin
        a[s] <= upd_left ? res : a_in;
        b[s] <= upd_left ? b_in : res;
      end
    end
  end

endmodule

`default_nettype wire
